// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the mixer RTL.
// Each macro expects clk_i and rst_ni to be visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RTEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define RTEM_ASSERT_NEVER(lbl, expr, msg) \
  `RTEM_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/rtem_pkg.sv -----
// Shared constants and types for the throttle and elevon mixer.
// No dependencies; used by rtem_muldiv and the top level.
`timescale 1ns / 1ps

package rtem_pkg;

  // Fixed field widths.
  localparam int unsigned CFG_W   = 12;  // configuration write data
  localparam int unsigned OUT_W   = 12;  // drive and status output fields
  localparam int unsigned LEVEL_W = 10;  // trigger readings
  localparam int unsigned AXIS_W  = 10;  // stick readings, signed
  localparam int unsigned DZ_W    = 10;  // deadzone register
  localparam int unsigned AMAX_W  = 9;   // axis_max register
  localparam int unsigned CIDX_W  = 3;   // configuration register index

  // Operand widths of the shared multiply-divide unit.
  localparam int unsigned A_W  = 12;     // multiplier operand, signed
  localparam int unsigned DV_W = 11;     // divisor, signed

  // Fixed operands of the throttle, brake and idle maps.
  localparam logic signed [DV_W-1:0] TRIG_SPAN = 11'sd1023;
  localparam logic signed [DV_W-1:0] IDLE_DIV  = 11'sd100;
  localparam logic signed [A_W-1:0]  IDLE_NUM  = 12'sd24;

  // Trigger selection codes; the unused code behaves as none.
  localparam logic [1:0] TRIG_NONE     = 2'd0;
  localparam logic [1:0] TRIG_THROTTLE = 2'd1;
  localparam logic [1:0] TRIG_BRAKE    = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_ESC_MIN   = 3'd0,
    CFG_ESC_MAX   = 3'd1,
    CFG_SERVO_MIN = 3'd2,
    CFG_SERVO_MAX = 3'd3,
    CFG_AXIS_DZ   = 3'd4,
    CFG_AXIS_MIN  = 3'd5,
    CFG_AXIS_MAX  = 3'd6
  } cfg_idx_e;

endpackage

// ----- hw/rtl/rtem_muldiv.sv -----
// Shared arithmetic unit: result = a * b / div + off, truncating toward zero.
// Uses rtem_pkg constants and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtem_muldiv #(
  parameter int unsigned OP_W = 14
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [rtem_pkg::A_W-1:0]           a_i,
  input  logic signed [OP_W-1:0]                    b_i,
  input  logic signed [rtem_pkg::DV_W-1:0]          div_i,
  input  logic signed [OP_W-1:0]                    off_i,
  output logic                                      done_o,
  output logic signed [rtem_pkg::A_W+OP_W:0]        result_o
);

  localparam int unsigned P_W   = rtem_pkg::A_W + OP_W;
  localparam int unsigned R_W   = P_W + 1;
  localparam int unsigned DV_W  = rtem_pkg::DV_W;
  localparam int unsigned CNT_W = $clog2(P_W + 1);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_PREP,
    A_DIV,
    A_ADD
  } state_e;

  state_e                  state_q;
  logic signed [rtem_pkg::A_W-1:0] a_q;
  logic signed [OP_W-1:0]  b_q;
  logic signed [DV_W-1:0]  div_q;
  logic signed [OP_W-1:0]  off_q;
  logic signed [P_W-1:0]   prod_q;
  logic [P_W-1:0]          quo_q;
  logic [DV_W-1:0]         rem_q;
  logic [DV_W-1:0]         dmag_q;
  logic                    neg_q;
  logic                    zero_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;
  logic signed [R_W-1:0]   result_q;

  // One restoring division step: shift in the next quotient bit, subtract if it fits.
  logic [DV_W:0]           rem_sh;
  logic [DV_W:0]           rem_sub;
  logic                    fits;
  logic signed [R_W-1:0]   quo_s;
  logic signed [R_W-1:0]   quo_signed;

  assign rem_sh     = {rem_q, quo_q[P_W-1]};
  assign rem_sub    = rem_sh - {1'b0, dmag_q};
  assign fits       = (rem_sh >= {1'b0, dmag_q});
  assign quo_s      = $signed({1'b0, quo_q});
  assign quo_signed = neg_q ? -quo_s : quo_s;

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= A_IDLE;
      a_q      <= '0;
      b_q      <= '0;
      div_q    <= '0;
      off_q    <= '0;
      prod_q   <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      dmag_q   <= '0;
      neg_q    <= 1'b0;
      zero_q   <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            div_q   <= div_i;
            off_q   <= off_i;
            state_q <= A_MUL;
          end
        end
        A_MUL: begin
          prod_q  <= P_W'(a_q) * P_W'(b_q);
          state_q <= A_PREP;
        end
        A_PREP: begin
          quo_q   <= prod_q[P_W-1] ? P_W'(-prod_q) : P_W'(prod_q);
          dmag_q  <= div_q[DV_W-1] ? DV_W'(-div_q) : DV_W'(div_q);
          neg_q   <= prod_q[P_W-1] ^ div_q[DV_W-1];
          zero_q  <= (div_q == '0);
          rem_q   <= '0;
          cnt_q   <= CNT_W'(P_W);
          state_q <= A_DIV;
        end
        A_DIV: begin
          if (fits) begin
            rem_q <= rem_sub[DV_W-1:0];
          end else begin
            rem_q <= rem_sh[DV_W-1:0];
          end
          quo_q <= {quo_q[P_W-2:0], fits};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= A_ADD;
          end
        end
        A_ADD: begin
          // A zero span yields the low output end.
          if (zero_q) begin
            result_q <= R_W'(off_q);
          end else begin
            result_q <= quo_signed + R_W'(off_q);
          end
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: begin
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `RTEM_ASSERT_NEVER(a_start_busy, start_i && (state_q != A_IDLE),
      "muldiv started while busy")
  `RTEM_ASSERT(a_done_pulse, done_q |=> !done_q, "muldiv done held for two cycles")
  `RTEM_ASSERT(a_rem_below, (state_q == A_DIV) && !zero_q |-> (rem_q < dmag_q),
      "division remainder not below divisor")

endmodule

// ----- hw/rtl/rc_throttle_and_elevon_mixer.sv -----
// Top level of the throttle and elevon mixer: sequencer, state and ports.
// Depends on rtem_pkg, rtem_muldiv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One controller sample per input word gives one result word. The engine
// flag toggles on a start event; the ESC drive follows the throttle, the
// brake or an idle level, and the two stick axes move the elevon servos.
// All maps run one after another through a single multiply and bit-serial
// divide unit, and an item runs up to three maps plus the sequencing steps
// (take, store, emit); no map runs when the engine is off and both axes
// sit in their deadzones. The input is not ready while an item is in work.
// The result word sits in an output register, so a pending result does not
// stop the next sample from being taken; an item that finishes while that
// register is still full waits in its emit step. Configuration writes are
// taken in any cycle and should only be issued while idle.
module rc_throttle_and_elevon_mixer #(
  parameter int unsigned DRIVE_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rtem_pkg::CIDX_W-1:0]           cfg_index_i,
  input  logic [rtem_pkg::CFG_W-1:0]            cfg_data_i,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  start_pressed_i,
  input  logic [1:0]                            trigger_choice_i,
  input  logic [rtem_pkg::LEVEL_W-1:0]          throttle_level_i,
  input  logic [rtem_pkg::LEVEL_W-1:0]          brake_level_i,
  input  logic signed [rtem_pkg::AXIS_W-1:0]    roll_axis_i,
  input  logic signed [rtem_pkg::AXIS_W-1:0]    pitch_axis_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  engine_running_o,
  output logic [rtem_pkg::OUT_W-1:0]            esc_drive_o,
  output logic [rtem_pkg::OUT_W-1:0]            speed_now_o,
  output logic                                  servo_update_o,
  output logic [rtem_pkg::OUT_W-1:0]            left_servo_drive_o,
  output logic [rtem_pkg::OUT_W-1:0]            right_servo_drive_o
);

  localparam int unsigned MAG_W = (DRIVE_BITS > 12) ? DRIVE_BITS : 12;
  localparam int unsigned B_W   = MAG_W + 2;
  localparam int unsigned P_W   = rtem_pkg::A_W + B_W;
  localparam int unsigned R_W   = P_W + 1;
  localparam int unsigned W_W   = R_W + 2;
  localparam int unsigned A_W   = rtem_pkg::A_W;
  localparam int unsigned DV_W  = rtem_pkg::DV_W;
  localparam int unsigned CFG_W = rtem_pkg::CFG_W;
  localparam int unsigned OUT_W = rtem_pkg::OUT_W;
  localparam logic signed [W_W-1:0] DRIVE_TOP = W_W'((1 << DRIVE_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ESC,
    S_ESC_WAIT,
    S_PITCH,
    S_PITCH_WAIT,
    S_ROLL,
    S_ROLL_WAIT,
    S_STORE,
    S_EMIT
  } state_e;

  // Saturate a working value into the drive range.
  function automatic logic [DRIVE_BITS-1:0] sat_drive(input logic signed [W_W-1:0] v);
    logic [DRIVE_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > DRIVE_TOP) begin
      r = DRIVE_TOP[DRIVE_BITS-1:0];
    end else begin
      r = v[DRIVE_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp, testing the low limit first.
  function automatic logic signed [W_W-1:0] limit(input logic signed [W_W-1:0] v,
                                                 input logic signed [W_W-1:0] lo,
                                                 input logic signed [W_W-1:0] hi);
    logic signed [W_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Fit a drive value onto a 12 bit output field.
  function automatic logic [OUT_W-1:0] fit_out(input logic [DRIVE_BITS-1:0] v);
    logic [MAG_W-1:0] wide;
    wide = MAG_W'(v);
    return wide[OUT_W-1:0];
  endfunction

  // Magnitude of a stick reading.
  function automatic logic [rtem_pkg::AXIS_W:0] abs_axis(
      input logic signed [rtem_pkg::AXIS_W-1:0] v);
    logic signed [rtem_pkg::AXIS_W:0] wide;
    wide = (rtem_pkg::AXIS_W + 1)'(v);
    return (wide < 0) ? (rtem_pkg::AXIS_W + 1)'(-wide) : (rtem_pkg::AXIS_W + 1)'(wide);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]                     esc_min_q;
  logic [CFG_W-1:0]                     esc_max_q;
  logic [CFG_W-1:0]                     servo_min_q;
  logic [CFG_W-1:0]                     servo_max_q;
  logic [rtem_pkg::DZ_W-1:0]            axis_dz_q;
  logic signed [rtem_pkg::AXIS_W-1:0]   axis_min_q;
  logic [rtem_pkg::AMAX_W-1:0]          axis_max_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_min_q   <= 12'd0;
      esc_max_q   <= 12'd180;
      servo_min_q <= 12'd0;
      servo_max_q <= 12'd180;
      axis_dz_q   <= 10'd50;
      axis_min_q  <= -10'sd512;
      axis_max_q  <= 9'd511;
    end else if (cfg_valid_i) begin
      case (rtem_pkg::cfg_idx_e'(cfg_index_i))
        rtem_pkg::CFG_ESC_MIN:   esc_min_q   <= cfg_data_i;
        rtem_pkg::CFG_ESC_MAX:   esc_max_q   <= cfg_data_i;
        rtem_pkg::CFG_SERVO_MIN: servo_min_q <= cfg_data_i;
        rtem_pkg::CFG_SERVO_MAX: servo_max_q <= cfg_data_i;
        rtem_pkg::CFG_AXIS_DZ:   axis_dz_q   <= cfg_data_i[rtem_pkg::DZ_W-1:0];
        rtem_pkg::CFG_AXIS_MIN:  axis_min_q  <= $signed(cfg_data_i[rtem_pkg::AXIS_W-1:0]);
        rtem_pkg::CFG_AXIS_MAX:  axis_max_q  <= cfg_data_i[rtem_pkg::AMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, state and result registers.
  state_e                              state_q;
  logic                                engine_q;
  logic [DRIVE_BITS-1:0]               speed_q;
  logic [DRIVE_BITS-1:0]               left_pos_q;
  logic [DRIVE_BITS-1:0]               right_pos_q;
  logic [DRIVE_BITS-1:0]               drive_q;
  logic [1:0]                          trig_q;
  logic [rtem_pkg::LEVEL_W-1:0]        thr_q;
  logic [rtem_pkg::LEVEL_W-1:0]        brk_q;
  logic signed [rtem_pkg::AXIS_W-1:0]  roll_q;
  logic signed [rtem_pkg::AXIS_W-1:0]  pitch_q;
  logic                                pitch_on_q;
  logic                                roll_on_q;
  logic signed [W_W-1:0]               left_w_q;
  logic signed [W_W-1:0]               right_w_q;
  logic                                out_valid_q;
  logic                                engine_out_q;
  logic [OUT_W-1:0]                    esc_out_q;
  logic [OUT_W-1:0]                    speed_out_q;
  logic                                upd_out_q;
  logic [OUT_W-1:0]                    left_out_q;
  logic [OUT_W-1:0]                    right_out_q;

  // Shared unit handshake.
  logic                                arith_start;
  logic signed [A_W-1:0]               arith_a;
  logic signed [B_W-1:0]               arith_b;
  logic signed [DV_W-1:0]              arith_div;
  logic signed [B_W-1:0]               arith_off;
  logic                                arith_done;
  logic signed [R_W-1:0]               arith_res;

  // Register values in signed working form.
  logic signed [B_W-1:0]  emin_s;
  logic signed [B_W-1:0]  emax_s;
  logic signed [B_W-1:0]  smin_s;
  logic signed [B_W-1:0]  smax_s;
  logic signed [B_W-1:0]  speed_s;
  logic signed [B_W-1:0]  half_s;
  logic signed [B_W-1:0]  twice_s;
  logic signed [DV_W-1:0] axis_span;
  logic signed [12:0]     sdiff;
  logic [12:0]            sdiff_abs;
  logic [11:0]            half;
  logic signed [W_W-1:0]  res_w;
  logic signed [W_W-1:0]  smin_w;
  logic signed [W_W-1:0]  smax_w;
  logic                   in_fire;
  logic                   engine_next;
  logic                   out_free;

  assign emin_s    = B_W'($signed({1'b0, esc_min_q}));
  assign emax_s    = B_W'($signed({1'b0, esc_max_q}));
  assign smin_s    = B_W'($signed({1'b0, servo_min_q}));
  assign smax_s    = B_W'($signed({1'b0, servo_max_q}));
  assign speed_s   = B_W'($signed({1'b0, speed_q}));
  assign sdiff     = 13'($signed({1'b0, servo_max_q})) - 13'($signed({1'b0, servo_min_q}));
  assign sdiff_abs = (sdiff < 0) ? 13'(-sdiff) : 13'(sdiff);
  assign half      = sdiff_abs[12:1];
  assign half_s    = B_W'($signed({1'b0, half}));
  assign twice_s   = B_W'($signed({1'b0, half, 1'b0}));
  assign axis_span = DV_W'($signed({2'b00, axis_max_q})) - DV_W'(axis_min_q);
  assign res_w     = W_W'(arith_res);
  assign smin_w    = W_W'(smin_s);
  assign smax_w    = W_W'(smax_s);

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign engine_next = engine_q ^ start_pressed_i;
  assign out_free    = !out_valid_q || out_ready_i;

  // Operand selection for the job issued in this state.
  always_comb begin
    arith_start = 1'b0;
    arith_a     = '0;
    arith_b     = '0;
    arith_div   = '0;
    arith_off   = '0;
    case (state_q)
      S_ESC: begin
        arith_start = 1'b1;
        case (trig_q)
          rtem_pkg::TRIG_THROTTLE: begin
            arith_a   = A_W'($signed({1'b0, thr_q}));
            arith_b   = emax_s - emin_s;
            arith_div = rtem_pkg::TRIG_SPAN;
            arith_off = emin_s;
          end
          rtem_pkg::TRIG_BRAKE: begin
            arith_a   = A_W'($signed({1'b0, brk_q}));
            arith_b   = emin_s - speed_s;
            arith_div = rtem_pkg::TRIG_SPAN;
            arith_off = speed_s;
          end
          default: begin
            arith_a   = rtem_pkg::IDLE_NUM;
            arith_b   = emax_s - emin_s;
            arith_div = rtem_pkg::IDLE_DIV;
            arith_off = emin_s;
          end
        endcase
      end
      S_PITCH: begin
        arith_start = pitch_on_q;
        arith_a     = A_W'(pitch_q) - A_W'(axis_min_q);
        arith_b     = smax_s - smin_s;
        arith_div   = axis_span;
        arith_off   = smin_s;
      end
      S_ROLL: begin
        arith_start = roll_on_q;
        arith_a     = A_W'(roll_q) - A_W'(axis_min_q);
        arith_b     = twice_s;
        arith_div   = axis_span;
        arith_off   = -half_s;
      end
      default: ;
    endcase
  end

  rtem_muldiv #(
    .OP_W (B_W)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (arith_start),
    .a_i      (arith_a),
    .b_i      (arith_b),
    .div_i    (arith_div),
    .off_i    (arith_off),
    .done_o   (arith_done),
    .result_o (arith_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      engine_q     <= 1'b0;
      speed_q      <= '0;
      left_pos_q   <= '0;
      right_pos_q  <= '0;
      drive_q      <= '0;
      trig_q       <= rtem_pkg::TRIG_NONE;
      thr_q        <= '0;
      brk_q        <= '0;
      roll_q       <= '0;
      pitch_q      <= '0;
      pitch_on_q   <= 1'b0;
      roll_on_q    <= 1'b0;
      left_w_q     <= '0;
      right_w_q    <= '0;
      out_valid_q  <= 1'b0;
      engine_out_q <= 1'b0;
      esc_out_q    <= '0;
      speed_out_q  <= '0;
      upd_out_q    <= 1'b0;
      left_out_q   <= '0;
      right_out_q  <= '0;
    end else begin
      // The emit step reloads the output register itself.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // Take a sample and toggle the engine.
        S_IDLE: begin
          if (in_fire) begin
            trig_q     <= trigger_choice_i;
            thr_q      <= throttle_level_i;
            brk_q      <= brake_level_i;
            roll_q     <= roll_axis_i;
            pitch_q    <= pitch_axis_i;
            pitch_on_q <= abs_axis(pitch_axis_i) > {1'b0, axis_dz_q};
            roll_on_q  <= abs_axis(roll_axis_i) > {1'b0, axis_dz_q};
            engine_q   <= engine_next;
            if (engine_next) begin
              state_q <= S_ESC;
            end else begin
              drive_q <= sat_drive(W_W'(emin_s));
              state_q <= S_PITCH;
            end
          end
        end
        S_ESC: begin
          state_q <= S_ESC_WAIT;
        end
        S_ESC_WAIT: begin
          if (arith_done) begin
            speed_q <= sat_drive(res_w);
            drive_q <= sat_drive(res_w);
            state_q <= S_PITCH;
          end
        end
        // Pitch sets the left servo and mirrors it on the right.
        S_PITCH: begin
          if (pitch_on_q) begin
            state_q <= S_PITCH_WAIT;
          end else begin
            left_w_q  <= W_W'($signed({1'b0, left_pos_q}));
            right_w_q <= W_W'($signed({1'b0, right_pos_q}));
            state_q   <= S_ROLL;
          end
        end
        S_PITCH_WAIT: begin
          if (arith_done) begin
            left_w_q  <= res_w;
            right_w_q <= smax_w - res_w + smin_w;
            state_q   <= S_ROLL;
          end
        end
        // Roll is added on the right and taken from the left, then clamped.
        S_ROLL: begin
          state_q <= roll_on_q ? S_ROLL_WAIT : S_STORE;
        end
        S_ROLL_WAIT: begin
          if (arith_done) begin
            left_w_q  <= limit(left_w_q - res_w, smin_w, smax_w);
            right_w_q <= limit(right_w_q + res_w, smin_w, smax_w);
            state_q   <= S_STORE;
          end
        end
        S_STORE: begin
          if (pitch_on_q || roll_on_q) begin
            left_pos_q  <= sat_drive(left_w_q);
            right_pos_q <= sat_drive(right_w_q);
          end
          state_q <= S_EMIT;
        end
        // Load the result word once the output register is free.
        S_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            engine_out_q <= engine_q;
            esc_out_q    <= fit_out(drive_q);
            speed_out_q  <= fit_out(speed_q);
            upd_out_q    <= pitch_on_q || roll_on_q;
            left_out_q   <= fit_out(sat_drive(smax_w - W_W'($signed({1'b0, left_pos_q}))
                                              + smin_w));
            right_out_q  <= fit_out(right_pos_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign engine_running_o    = engine_out_q;
  assign esc_drive_o         = esc_out_q;
  assign speed_now_o         = speed_out_q;
  assign servo_update_o      = upd_out_q;
  assign left_servo_drive_o  = left_out_q;
  assign right_servo_drive_o = right_out_q;

  `RTEM_ASSERT(a_done_in_wait, arith_done |-> (state_q == S_ESC_WAIT ||
      state_q == S_PITCH_WAIT || state_q == S_ROLL_WAIT),
      "arithmetic result arrived outside a wait state")
  `RTEM_ASSERT(a_pos_hold, (state_q != S_STORE) |=> ($stable(left_pos_q) &&
      $stable(right_pos_q)), "servo positions changed outside the store step")
  `RTEM_ASSERT(a_out_hold, out_valid_q && !out_ready_i |=> (out_valid_q &&
      $stable(esc_out_q) && $stable(left_out_q) && $stable(right_out_q)),
      "result word changed while waiting")

endmodule

// ----- tb/rc_throttle_and_elevon_mixer_checker.sv -----
// Checker for the throttle and elevon mixer: tracks configuration writes,
// predicts one result word per accepted sample and compares field by field.
// Depends on rtem_pkg for field widths and register indexes.
`timescale 1ns / 1ps

module rc_throttle_and_elevon_mixer_checker #(
  parameter int unsigned DRIVE_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [rtem_pkg::CIDX_W-1:0]           cfg_index_i,
  input  logic [rtem_pkg::CFG_W-1:0]            cfg_data_i,
  // Sample channel
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic                                  start_pressed_i,
  input  logic [1:0]                            trigger_choice_i,
  input  logic [rtem_pkg::LEVEL_W-1:0]          throttle_level_i,
  input  logic [rtem_pkg::LEVEL_W-1:0]          brake_level_i,
  input  logic signed [rtem_pkg::AXIS_W-1:0]    roll_axis_i,
  input  logic signed [rtem_pkg::AXIS_W-1:0]    pitch_axis_i,
  // Result channel
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic                                  engine_running_i,
  input  logic [rtem_pkg::OUT_W-1:0]            esc_drive_i,
  input  logic [rtem_pkg::OUT_W-1:0]            speed_now_i,
  input  logic                                  servo_update_i,
  input  logic [rtem_pkg::OUT_W-1:0]            left_servo_drive_i,
  input  logic [rtem_pkg::OUT_W-1:0]            right_servo_drive_i,
  // Status toward the testbench top
  input  logic                                  drain_check_i,
  output int                                    errors_o,
  output int                                    pending_o
);

  localparam int unsigned CFG_W   = rtem_pkg::CFG_W;
  localparam int unsigned OUT_W   = rtem_pkg::OUT_W;
  localparam int unsigned LEVEL_W = rtem_pkg::LEVEL_W;
  localparam int unsigned AXIS_W  = rtem_pkg::AXIS_W;
  localparam int unsigned DZ_W    = rtem_pkg::DZ_W;
  localparam int unsigned AMAX_W  = rtem_pkg::AMAX_W;

  localparam int DRIVE_TOP = (1 << DRIVE_BITS) - 1;
  localparam int LEVEL_TOP = 1023;
  localparam int IDLE_PCT  = 24;

  typedef struct packed {
    logic             engine_running;
    logic [OUT_W-1:0] esc_drive;
    logic [OUT_W-1:0] speed_now;
    logic             servo_update;
    logic [OUT_W-1:0] left_drive;
    logic [OUT_W-1:0] right_drive;
  } mix_word_t;

  // Configuration copy.
  logic [CFG_W-1:0]         esc_lo, esc_hi, servo_lo, servo_hi;
  logic [DZ_W-1:0]          dead_band;
  logic signed [AXIS_W-1:0] stick_lo;
  logic [AMAX_W-1:0]        stick_hi;

  // Mixer state: engine flag, stored speed and logical servo positions.
  logic engine_on;
  int   speed, left_pos, right_pos;

  mix_word_t pending_mix_words [$];

  initial errors_o = 0;

  function automatic int mag_of(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Linear map with division truncating toward zero; a zero span gives c.
  function automatic int span_map(int x, int a, int b, int c, int d);
    if (b == a) return c;
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  function automatic int sat_drive(int v);
    if (v < 0) return 0;
    if (v > DRIVE_TOP) return DRIVE_TOP;
    return v;
  endfunction

  // The low limit is tested first, so with inverted limits a value below the low one gets it.
  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the mixer state by one sample and returns its result word.
  function automatic mix_word_t mix_sample(logic start, logic [1:0] choice,
                                           logic [LEVEL_W-1:0] thr,
                                           logic [LEVEL_W-1:0] brk,
                                           logic signed [AXIS_W-1:0] roll,
                                           logic signed [AXIS_W-1:0] pitch);
    int emin, emax, smin, smax, amin, amax, dz;
    int sp, drive, left, right, half, p, r;
    logic pitch_on, roll_on;
    mix_word_t w;
    emin = int'(esc_lo);
    emax = int'(esc_hi);
    smin = int'(servo_lo);
    smax = int'(servo_hi);
    amin = int'(stick_lo);
    amax = int'(stick_hi);
    dz   = int'(dead_band);

    if (start) engine_on = !engine_on;

    // ESC drive from throttle, brake or idle while running.
    if (engine_on) begin
      if (choice == rtem_pkg::TRIG_THROTTLE) begin
        sp = span_map(int'(thr), 0, LEVEL_TOP, emin, emax);
      end else if (choice == rtem_pkg::TRIG_BRAKE) begin
        sp = span_map(int'(brk), 0, LEVEL_TOP, speed, emin);
      end else begin
        sp = emin + (emax - emin) * IDLE_PCT / 100;
      end
      speed = sat_drive(sp);
      drive = speed;
    end else begin
      drive = sat_drive(emin);
    end

    // Elevon mixing: pitch mirrors the two sides, roll pulls them apart.
    left     = left_pos;
    right    = right_pos;
    pitch_on = mag_of(int'(pitch)) > dz;
    roll_on  = mag_of(int'(roll)) > dz;
    if (pitch_on) begin
      p     = span_map(int'(pitch), amin, amax, smin, smax);
      left  = p;
      right = smax - p + smin;
    end
    if (roll_on) begin
      half  = mag_of(smax - smin) / 2;
      r     = span_map(int'(roll), amin, amax, -half, half);
      left  = clamp_to(left - r, smin, smax);
      right = clamp_to(right + r, smin, smax);
    end
    if (pitch_on || roll_on) begin
      left_pos  = sat_drive(left);
      right_pos = sat_drive(right);
    end

    w.engine_running = engine_on;
    w.esc_drive      = drive[OUT_W-1:0];
    w.speed_now      = speed[OUT_W-1:0];
    w.servo_update   = pitch_on || roll_on;
    w.left_drive     = OUT_W'(sat_drive(smax - left_pos + smin));
    w.right_drive    = right_pos[OUT_W-1:0];
    return w;
  endfunction

  task automatic report_fault(string msg);
    $display("[%0t] mixer check: %s", $realtime, msg);
    errors_o++;
  endtask

  task automatic check_field(string name, logic [OUT_W-1:0] got,
                             logic [OUT_W-1:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Register writes, result comparison and prediction at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    mix_word_t want;
    if (!rst_ni) begin
      esc_lo    = '0;
      esc_hi    = CFG_W'(180);
      servo_lo  = '0;
      servo_hi  = CFG_W'(180);
      dead_band = DZ_W'(50);
      stick_lo  = -AXIS_W'(512);
      stick_hi  = AMAX_W'(511);
      engine_on = 1'b0;
      speed     = 0;
      left_pos  = 0;
      right_pos = 0;
      pending_mix_words.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (rtem_pkg::cfg_idx_e'(cfg_index_i))
          rtem_pkg::CFG_ESC_MIN:   esc_lo    = cfg_data_i;
          rtem_pkg::CFG_ESC_MAX:   esc_hi    = cfg_data_i;
          rtem_pkg::CFG_SERVO_MIN: servo_lo  = cfg_data_i;
          rtem_pkg::CFG_SERVO_MAX: servo_hi  = cfg_data_i;
          rtem_pkg::CFG_AXIS_DZ:   dead_band = cfg_data_i[DZ_W-1:0];
          rtem_pkg::CFG_AXIS_MIN:  stick_lo  = cfg_data_i[AXIS_W-1:0];
          rtem_pkg::CFG_AXIS_MAX:  stick_hi  = cfg_data_i[AMAX_W-1:0];
          default: ;
        endcase
      end

      // A result word always belongs to a sample taken at an earlier edge.
      if (out_valid_i && out_ready_i) begin
        if (pending_mix_words.size() == 0) begin
          report_fault("result word arrived with no sample outstanding");
        end else begin
          want = pending_mix_words.pop_front();
          check_field("engine_running", OUT_W'(engine_running_i),
                      OUT_W'(want.engine_running));
          check_field("esc_drive", esc_drive_i, want.esc_drive);
          check_field("speed_now", speed_now_i, want.speed_now);
          check_field("servo_update", OUT_W'(servo_update_i),
                      OUT_W'(want.servo_update));
          check_field("left_servo_drive", left_servo_drive_i, want.left_drive);
          check_field("right_servo_drive", right_servo_drive_i, want.right_drive);
        end
      end

      if (in_valid_i && in_ready_i) begin
        pending_mix_words.push_back(mix_sample(start_pressed_i, trigger_choice_i,
                                               throttle_level_i, brake_level_i,
                                               roll_axis_i, pitch_axis_i));
      end
      pending_o = pending_mix_words.size();
    end
  end

  // At the end of the run no prediction may be left waiting.
  always @(posedge drain_check_i) begin
    if (pending_mix_words.size() != 0) begin
      report_fault($sformatf("%0d result words never arrived",
                             pending_mix_words.size()));
    end
  end

endmodule

// ----- tb/rc_throttle_and_elevon_mixer_tb.sv -----
// Testbench top for the throttle and elevon mixer: clock, reset, stimulus,
// register settings and the verdict. Depends on rtem_pkg, the mixer RTL and
// rc_throttle_and_elevon_mixer_checker.
`timescale 1ns / 1ps

module rc_throttle_and_elevon_mixer_tb;

  localparam int unsigned CIDX_W  = rtem_pkg::CIDX_W;
  localparam int unsigned CFG_W   = rtem_pkg::CFG_W;
  localparam int unsigned LEVEL_W = rtem_pkg::LEVEL_W;
  localparam int unsigned AXIS_W  = rtem_pkg::AXIS_W;
  localparam int unsigned OUT_W   = rtem_pkg::OUT_W;

  localparam int unsigned MIX_DRIVE_BITS = 12;
  localparam int unsigned RUN_LIMIT_NS   = 8_000_000;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          PHASE_COUNT    = 9;
  localparam int          PHASE_WORDS    = 150;
  localparam int          DRAIN_CYCLES   = 200;

  // Trigger code the block treats like no trigger.
  localparam logic [1:0]        TRIG_UNUSED = 2'd3;
  // Register index that matches no register.
  localparam logic [CIDX_W-1:0] CFG_NO_REG  = 3'd7;

  typedef enum int {
    SET_DEFAULT, SET_RANDOM, SET_WIDE, SET_REVERSED, SET_NARROW, SET_TIGHT
  } setting_e;

  logic                     clk_i, rst_ni;
  logic                     cfg_valid_i, cfg_ready_o;
  logic [CIDX_W-1:0]        cfg_index_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i, in_ready_o;
  logic                     start_pressed_i;
  logic [1:0]               trigger_choice_i;
  logic [LEVEL_W-1:0]       throttle_level_i, brake_level_i;
  logic signed [AXIS_W-1:0] roll_axis_i, pitch_axis_i;
  logic                     out_valid_o, out_ready_i;
  logic                     engine_running_o, servo_update_o;
  logic [OUT_W-1:0]         esc_drive_o, speed_now_o;
  logic [OUT_W-1:0]         left_servo_drive_o, right_servo_drive_o;
  logic                     drain_check;
  int                       mix_errors, words_pending;

  int unsigned tx_idle_pct, rx_idle_pct;
  int          cur_dead_band;
  bit          hold_req;

  rc_throttle_and_elevon_mixer #(
    .DRIVE_BITS (MIX_DRIVE_BITS)
  ) DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .start_pressed_i, .trigger_choice_i,
    .throttle_level_i, .brake_level_i, .roll_axis_i, .pitch_axis_i,
    .out_valid_o, .out_ready_i, .engine_running_o, .esc_drive_o, .speed_now_o,
    .servo_update_o, .left_servo_drive_o, .right_servo_drive_o
  );

  rc_throttle_and_elevon_mixer_checker #(
    .DRIVE_BITS (MIX_DRIVE_BITS)
  ) u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i (in_ready_o), .start_pressed_i, .trigger_choice_i,
    .throttle_level_i, .brake_level_i, .roll_axis_i, .pitch_axis_i,
    .out_valid_i (out_valid_o), .out_ready_i,
    .engine_running_i (engine_running_o), .esc_drive_i (esc_drive_o),
    .speed_now_i (speed_now_o), .servo_update_i (servo_update_o),
    .left_servo_drive_i (left_servo_drive_o),
    .right_servo_drive_i (right_servo_drive_o),
    .drain_check_i (drain_check), .errors_o (mix_errors),
    .pending_o (words_pending)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Result receiver: random back-pressure, plus one long hold-off on request
  // so that the block fills up and stops taking samples.
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Writes one register word; valid drops at the following falling edge.
  task automatic write_reg(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= index;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(int e_lo, int e_hi, int s_lo, int s_hi, int dz,
                         int a_lo, int a_hi);
    write_reg(rtem_pkg::CFG_ESC_MIN,   CFG_W'(e_lo));
    write_reg(rtem_pkg::CFG_ESC_MAX,   CFG_W'(e_hi));
    write_reg(rtem_pkg::CFG_SERVO_MIN, CFG_W'(s_lo));
    write_reg(rtem_pkg::CFG_SERVO_MAX, CFG_W'(s_hi));
    write_reg(rtem_pkg::CFG_AXIS_DZ,   CFG_W'(dz));
    write_reg(rtem_pkg::CFG_AXIS_MIN,  CFG_W'(a_lo));
    write_reg(rtem_pkg::CFG_AXIS_MAX,  CFG_W'(a_hi));
    cur_dead_band = dz;
  endtask

  task automatic apply_setting(setting_e kind);
    case (kind)
      SET_DEFAULT:  set_all(0, 180, 0, 180, 50, -512, 511);
      SET_WIDE:     set_all(0, 4095, 0, 4095, 0, -512, 511);
      SET_REVERSED: set_all(4095, 0, 4095, 0, 512, 0, 0);
      SET_NARROW:   set_all(2000, 1000, 3000, 1000, 20, -100, 100);
      SET_TIGHT:    set_all(0, 4095, 100, 4000, 511, -1, 1);
      default: begin
        set_all($urandom_range(4095), $urandom_range(4095),
                $urandom_range(4095), $urandom_range(4095),
                $urandom_range(160), -int'($urandom_range(512)),
                $urandom_range(511));
      end
    endcase
  endtask

  // Offers one sample word, idling first at random, and waits until taken.
  task automatic send_sample(logic start, logic [1:0] choice,
                             int thr, int brk, int roll, int pitch);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    start_pressed_i  <= start;
    trigger_choice_i <= choice;
    throttle_level_i <= LEVEL_W'(thr);
    brake_level_i    <= LEVEL_W'(brk);
    roll_axis_i      <= AXIS_W'(roll);
    pitch_axis_i     <= AXIS_W'(pitch);
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering and waits until every predicted word has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  function automatic int rand_level();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1023;
      default: return $urandom_range(1023);
    endcase
  endfunction

  // Stick readings: the ends, the deadzone edge, inside it, anywhere.
  function automatic int rand_axis(int dz);
    int mag;
    int v;
    mag = 0;
    v   = 0;
    case ($urandom_range(7))
      0: v = -512;
      1: v = 511;
      2: begin
        mag = dz + int'($urandom_range(1));
        if (mag > 511) mag = 511;
        v = $urandom_range(1) ? -mag : mag;
      end
      3: begin
        mag = $urandom_range((dz > 511) ? 511 : dz);
        v = $urandom_range(1) ? -mag : mag;
      end
      default: v = int'($urandom_range(1023)) - 512;
    endcase
    return v;
  endfunction

  // Mostly throttle and brake with an occasional start press.
  task automatic send_random();
    logic [1:0] choice;
    case ($urandom_range(9))
      0, 1, 2, 3: choice = rtem_pkg::TRIG_THROTTLE;
      4, 5, 6:    choice = rtem_pkg::TRIG_BRAKE;
      7, 8:       choice = rtem_pkg::TRIG_NONE;
      default:    choice = TRIG_UNUSED;
    endcase
    send_sample($urandom_range(99) < 8, choice, rand_level(), rand_level(),
                rand_axis(cur_dead_band), rand_axis(cur_dead_band));
  endtask

  function automatic setting_e setting_for(int ph);
    case (ph)
      0:       return SET_WIDE;
      2:       return SET_NARROW;
      4:       return SET_REVERSED;
      6:       return SET_DEFAULT;
      8:       return SET_TIGHT;
      default: return SET_RANDOM;
    endcase
  endfunction

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin
        tx_idle_pct = 12;
        rx_idle_pct = 57;
      end
      1: begin
        tx_idle_pct = 57;
        rx_idle_pct = 12;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  // Reset, directed samples, then random phases under changing settings.
  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    start_pressed_i  = 1'b0;
    trigger_choice_i = rtem_pkg::TRIG_NONE;
    throttle_level_i = '0;
    brake_level_i    = '0;
    roll_axis_i      = '0;
    pitch_axis_i     = '0;
    drain_check      = 1'b0;
    hold_req         = 1'b0;
    cur_dead_band    = 50;
    set_idle_mode(0);
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // A write to an unused index must leave the reset settings alone.
    write_reg(CFG_NO_REG, '1);

    // Engine off, start, throttle ends, brake from the held speed, idle.
    send_sample(1'b0, rtem_pkg::TRIG_NONE,     0,    0,    0,    0);
    send_sample(1'b1, rtem_pkg::TRIG_THROTTLE, 1023, 0,    0,    0);
    send_sample(1'b0, rtem_pkg::TRIG_BRAKE,    0,    0,    0,    0);
    send_sample(1'b0, rtem_pkg::TRIG_BRAKE,    0,    512,  0,    0);
    send_sample(1'b0, rtem_pkg::TRIG_BRAKE,    0,    1023, 0,    0);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 0,    0,    0,    0);
    send_sample(1'b0, rtem_pkg::TRIG_NONE,     600,  0,    0,    0);
    send_sample(1'b0, TRIG_UNUSED,             1023, 1023, 0,    0);
    // Stick ends and both sides of the deadzone edge.
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 700,  0,    0,    511);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 700,  0,    0,    -512);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 700,  0,    50,   50);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 700,  0,    -50,  -51);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 700,  0,    511,  0);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 700,  0,    -512, 300);
    // Second start press turns the engine off again.
    send_sample(1'b1, rtem_pkg::TRIG_THROTTLE, 1023, 0,    200,  -200);
    wait_idle();

    // Zero axis span together with inverted servo and ESC limits.
    set_all(4000, 100, 3000, 1000, 10, 0, 0);
    send_sample(1'b1, rtem_pkg::TRIG_THROTTLE, 512,  0,    -200, 300);
    send_sample(1'b0, rtem_pkg::TRIG_BRAKE,    0,    700,  400,  0);
    wait_idle();

    // Narrow stick range so readings outside it overflow the drive range.
    set_all(0, 4095, 0, 4095, 0, -100, 100);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 1023, 0,    511,  -512);
    send_sample(1'b0, rtem_pkg::TRIG_THROTTLE, 1,    0,    -512, 511);
    send_sample(1'b0, rtem_pkg::TRIG_NONE,     0,    0,    0,    0);
    send_sample(1'b0, rtem_pkg::TRIG_BRAKE,    0,    300,  0,    1);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      apply_setting(setting_for(ph));
      set_idle_mode(ph / 3);
      if (ph == 6) hold_req = 1'b1;
      repeat (PHASE_WORDS) send_random();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    drain_check = 1'b1;
    @(negedge clk_i);
    if (mix_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
